// ===== sv/ttm_pkg.sv =====
// Shared widths, register map, command codes and interface types of the track mixer.
package ttm_pkg;

    localparam int LVL_W  = 13;              // levels and configuration values
    localparam int VAL_W  = 16;              // command value
    localparam int SUM_W  = 16;              // signed mixed level before scaling
    localparam int MAG_W  = 14;              // magnitude of a mixed level
    localparam int PROD_W = MAG_W + LVL_W;   // magnitude of level times output_max
    localparam int QUO_W  = 14;              // quotient bits kept by the divider
    localparam int SPD_W  = 14;              // output speed
    localparam int CNT_W  = $clog2(QUO_W + 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_DEAD_BAND     = 3'd0;
    localparam logic [2:0] REG_INPUT_MIN     = 3'd1;
    localparam logic [2:0] REG_INPUT_MAX     = 3'd2;
    localparam logic [2:0] REG_OUTPUT_MAX    = 3'd3;
    localparam logic [2:0] REG_START_ENABLED = 3'd4;

    localparam logic [1:0] FUNC_THROTTLE = 2'd0;
    localparam logic [1:0] FUNC_STEERING = 2'd1;
    localparam logic [1:0] FUNC_ENABLE   = 2'd2;

    localparam int RST_DEAD_BAND_I  = 10;
    localparam int RST_INPUT_MIN_I  = 0;
    localparam int RST_INPUT_MAX_I  = 255;
    localparam int RST_OUTPUT_MAX_I = 255;
    localparam int RST_MID_I = RST_INPUT_MIN_I + (RST_INPUT_MAX_I - RST_INPUT_MIN_I) / 2;

    localparam logic [LVL_W-1:0] RST_DEAD_BAND  = LVL_W'(RST_DEAD_BAND_I);
    localparam logic [LVL_W-1:0] RST_INPUT_MIN  = LVL_W'(RST_INPUT_MIN_I);
    localparam logic [LVL_W-1:0] RST_INPUT_MAX  = LVL_W'(RST_INPUT_MAX_I);
    localparam logic [LVL_W-1:0] RST_OUTPUT_MAX = LVL_W'(RST_OUTPUT_MAX_I);
    localparam logic [LVL_W-1:0] RST_MID        = LVL_W'(RST_MID_I);
    localparam logic             RST_START_EN   = 1'b1;

    localparam logic [SPD_W-1:0] SPD_POS_SAT = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic [SPD_W-1:0] SPD_NEG_SAT = {1'b1, {(SPD_W-1){1'b0}}};

    typedef struct packed {
        logic [LVL_W-1:0] dead_band;
        logic [LVL_W-1:0] input_min;
        logic [LVL_W-1:0] input_max;
        logic [LVL_W-1:0] output_max;
    } t_cfg;

    typedef struct packed {
        logic recenter;
        logic set_active;
        logic active_val;
    } t_cfg_evt;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [LVL_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== sv/tank_track_mixer.sv =====
// Top level of the tank track mixer: registers, sequencer and shared divider.
//
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   i_func, i_value
//   out       output      o_out_valid / i_out_stall o_left_speed, o_right_speed, o_scale_error
//   config    input       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// An enable command, an ignored command, or one that arrives while disabled returns to idle from S_UPDATE.
// A throttle or steering beat runs S_UPDATE and S_MIX, then per speed a multiply state, a divider start
// state and a wait on the 14 one-bit steps, then S_OUT; an overflowing quotient skips the steps.
// With input_max at zero the divider is skipped and the beat goes from S_MIX straight to S_OUT.
// Reset is synchronous; it restores the register defaults and centers both levels.
// A finished result waits in the output register while the next beat is accepted.
module tank_track_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ttm_pkg::ADDR_W-1:0]        paddr,
    input  logic [ttm_pkg::DATA_W-1:0]        pwdata,
    output logic [ttm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic signed [ttm_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ttm_pkg::SPD_W-1:0]  o_left_speed,
    output logic signed [ttm_pkg::SPD_W-1:0]  o_right_speed,
    output logic                              o_scale_error
);

    ttm_pkg::t_cfg     w_cfg;
    ttm_pkg::t_cfg_evt w_evt;
    ttm_pkg::t_div_req w_div_req;
    ttm_pkg::t_div_rsp w_div_rsp;

    ttm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_evt   (w_evt)
    );

    ttm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    ttm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_evt         (w_evt),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .o_scale_error (o_scale_error),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp)
    );

endmodule

// ===== sv/ttm_regs.sv =====
// Configuration register file with APB-style access and recenter/enable events.
module ttm_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttm_pkg::ADDR_W-1:0]  paddr,
    input  logic [ttm_pkg::DATA_W-1:0]  pwdata,
    output logic [ttm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ttm_pkg::t_cfg               o_cfg,
    output ttm_pkg::t_cfg_evt           o_evt
);

    ttm_pkg::t_cfg     r_cfg;
    ttm_pkg::t_cfg_evt r_evt;
    logic              r_start_en;
    logic              w_wr;
    logic [2:0]        w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign o_evt  = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_band  <= ttm_pkg::RST_DEAD_BAND;
            r_cfg.input_min  <= ttm_pkg::RST_INPUT_MIN;
            r_cfg.input_max  <= ttm_pkg::RST_INPUT_MAX;
            r_cfg.output_max <= ttm_pkg::RST_OUTPUT_MAX;
            r_start_en       <= ttm_pkg::RST_START_EN;
            r_evt            <= '0;
        end else begin
            r_evt.recenter   <= w_wr && (w_idx == ttm_pkg::REG_INPUT_MIN ||
                                         w_idx == ttm_pkg::REG_INPUT_MAX);
            r_evt.set_active <= w_wr && (w_idx == ttm_pkg::REG_START_ENABLED);
            r_evt.active_val <= pwdata[0];
            if (w_wr) begin
                case (w_idx)
                    ttm_pkg::REG_DEAD_BAND:     r_cfg.dead_band  <= pwdata[ttm_pkg::LVL_W-1:0];
                    ttm_pkg::REG_INPUT_MIN:     r_cfg.input_min  <= pwdata[ttm_pkg::LVL_W-1:0];
                    ttm_pkg::REG_INPUT_MAX:     r_cfg.input_max  <= pwdata[ttm_pkg::LVL_W-1:0];
                    ttm_pkg::REG_OUTPUT_MAX:    r_cfg.output_max <= pwdata[ttm_pkg::LVL_W-1:0];
                    ttm_pkg::REG_START_ENABLED: r_start_en       <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (w_idx)
            ttm_pkg::REG_DEAD_BAND:     prdata = ttm_pkg::DATA_W'(r_cfg.dead_band);
            ttm_pkg::REG_INPUT_MIN:     prdata = ttm_pkg::DATA_W'(r_cfg.input_min);
            ttm_pkg::REG_INPUT_MAX:     prdata = ttm_pkg::DATA_W'(r_cfg.input_max);
            ttm_pkg::REG_OUTPUT_MAX:    prdata = ttm_pkg::DATA_W'(r_cfg.output_max);
            ttm_pkg::REG_START_ENABLED: prdata = ttm_pkg::DATA_W'(r_start_en);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== sv/ttm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, with overflow detect.
module ttm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttm_pkg::t_div_req i_req,
    output ttm_pkg::t_div_rsp o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_ovf;
    logic [ttm_pkg::CNT_W-1:0]  r_cnt;
    logic [ttm_pkg::LVL_W-1:0]  r_rem;
    logic [ttm_pkg::QUO_W-1:0]  r_low;
    logic [ttm_pkg::LVL_W-1:0]  r_den;
    logic                       w_ovf;
    logic [ttm_pkg::LVL_W:0]    w_trial;
    logic                       w_ge;

    // A quotient that needs more than QUO_W bits only matters as a saturation flag.
    assign w_ovf   = i_req.num >= {i_req.den, {ttm_pkg::QUO_W{1'b0}}};
    assign w_trial = {r_rem, r_low[ttm_pkg::QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num[ttm_pkg::PROD_W-1:ttm_pkg::QUO_W];
                r_low  <= i_req.num[ttm_pkg::QUO_W-1:0];
                r_den  <= i_req.den;
                r_cnt  <= ttm_pkg::CNT_W'(ttm_pkg::QUO_W);
                r_ovf  <= w_ovf;
                r_busy <= !w_ovf;
                r_done <= w_ovf;
            end else if (r_busy) begin
                r_rem <= w_ge ? ttm_pkg::LVL_W'(w_trial - {1'b0, r_den})
                              : w_trial[ttm_pkg::LVL_W-1:0];
                r_low <= {r_low[ttm_pkg::QUO_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ttm_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/ttm_ctrl.sv =====
// Sequencer: level tracking, mixing, shared multiply, divider control and output register.
module ttm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ttm_pkg::t_cfg                     i_cfg,
    input  ttm_pkg::t_cfg_evt                 i_evt,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic signed [ttm_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ttm_pkg::SPD_W-1:0]  o_left_speed,
    output logic signed [ttm_pkg::SPD_W-1:0]  o_right_speed,
    output logic                              o_scale_error,
    output ttm_pkg::t_div_req                 o_div_req,
    input  ttm_pkg::t_div_rsp                 i_div_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MIX,
        S_MUL,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                                r_state;
    logic [1:0]                            r_func;
    logic signed [ttm_pkg::VAL_W-1:0]      r_value;
    logic                                  r_active;
    logic [ttm_pkg::LVL_W-1:0]             r_thr;
    logic [ttm_pkg::LVL_W-1:0]             r_str;
    logic signed [ttm_pkg::SUM_W-1:0]      r_sum_l;
    logic signed [ttm_pkg::SUM_W-1:0]      r_sum_r;
    logic                                  r_phase;
    logic                                  r_neg;
    logic [ttm_pkg::PROD_W-1:0]            r_prod;
    logic [ttm_pkg::SPD_W-1:0]             r_left;
    logic [ttm_pkg::SPD_W-1:0]             r_right;
    logic                                  r_err;
    logic                                  r_out_valid;
    logic [ttm_pkg::SPD_W-1:0]             r_out_left;
    logic [ttm_pkg::SPD_W-1:0]             r_out_right;
    logic                                  r_out_err;

    logic signed [ttm_pkg::LVL_W:0]        w_diff;
    logic signed [ttm_pkg::LVL_W:0]        w_half;
    logic signed [ttm_pkg::LVL_W:0]        w_mid_s;
    logic [ttm_pkg::LVL_W-1:0]             w_mid;
    logic signed [ttm_pkg::VAL_W:0]        w_v;
    logic signed [ttm_pkg::VAL_W:0]        w_lo;
    logic signed [ttm_pkg::VAL_W:0]        w_hi;
    logic signed [ttm_pkg::VAL_W:0]        w_c1;
    logic signed [ttm_pkg::VAL_W:0]        w_c2;
    logic [ttm_pkg::LVL_W-1:0]             w_clamped;
    logic signed [ttm_pkg::LVL_W:0]        w_dist;
    logic [ttm_pkg::LVL_W:0]               w_adist;
    logic [ttm_pkg::LVL_W-1:0]             w_thr_new;
    logic signed [ttm_pkg::SUM_W-1:0]      w_thr_s;
    logic signed [ttm_pkg::SUM_W-1:0]      w_str_s;
    logic signed [ttm_pkg::SUM_W-1:0]      w_mid_w;
    logic signed [ttm_pkg::SUM_W-1:0]      w_sel;
    logic [ttm_pkg::SUM_W-1:0]             w_mag_full;
    logic [ttm_pkg::MAG_W-1:0]             w_mag;
    logic [ttm_pkg::SPD_W-1:0]             w_sat;

    // Midpoint of the input range; the halving truncates toward zero.
    always_comb begin
        w_diff  = $signed({1'b0, i_cfg.input_max}) - $signed({1'b0, i_cfg.input_min});
        w_half  = (w_diff + $signed((ttm_pkg::LVL_W+1)'(w_diff[ttm_pkg::LVL_W]))) >>> 1;
        w_mid_s = $signed({1'b0, i_cfg.input_min}) + w_half;
        w_mid   = w_mid_s[ttm_pkg::LVL_W-1:0];
    end

    // Clamp against the ceiling first, then the floor, so an inverted range ends at the floor.
    always_comb begin
        w_v       = (ttm_pkg::VAL_W+1)'(r_value);
        w_lo      = $signed((ttm_pkg::VAL_W+1)'(i_cfg.input_min));
        w_hi      = $signed((ttm_pkg::VAL_W+1)'(i_cfg.input_max));
        w_c1      = (w_v > w_hi) ? w_hi : w_v;
        w_c2      = (w_c1 < w_lo) ? w_lo : w_c1;
        w_clamped = w_c2[ttm_pkg::LVL_W-1:0];
        w_dist    = $signed({1'b0, w_clamped}) - $signed({1'b0, w_mid});
        w_adist   = w_dist[ttm_pkg::LVL_W] ? (ttm_pkg::LVL_W+1)'(-w_dist)
                                           : (ttm_pkg::LVL_W+1)'(w_dist);
        w_thr_new = (w_adist < {1'b0, i_cfg.dead_band}) ? w_mid : w_clamped;
    end

    always_comb begin
        w_thr_s    = $signed(ttm_pkg::SUM_W'(r_thr));
        w_str_s    = $signed(ttm_pkg::SUM_W'(r_str));
        w_mid_w    = $signed(ttm_pkg::SUM_W'(w_mid));
        w_sel      = r_phase ? r_sum_r : r_sum_l;
        w_mag_full = w_sel[ttm_pkg::SUM_W-1] ? ttm_pkg::SUM_W'(-w_sel) : ttm_pkg::SUM_W'(w_sel);
        w_mag      = w_mag_full[ttm_pkg::MAG_W-1:0];
    end

    // Saturate the signed quotient to the speed field range.
    always_comb begin
        if (r_neg) begin
            if (i_div_rsp.ovf || i_div_rsp.quo > ttm_pkg::QUO_W'(ttm_pkg::SPD_NEG_SAT)) begin
                w_sat = ttm_pkg::SPD_NEG_SAT;
            end else begin
                w_sat = ttm_pkg::SPD_W'(-i_div_rsp.quo);
            end
        end else begin
            if (i_div_rsp.ovf || i_div_rsp.quo > ttm_pkg::QUO_W'(ttm_pkg::SPD_POS_SAT)) begin
                w_sat = ttm_pkg::SPD_POS_SAT;
            end else begin
                w_sat = ttm_pkg::SPD_W'(i_div_rsp.quo);
            end
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_div_req.start = (r_state == S_START);
    assign o_div_req.num   = r_prod;
    assign o_div_req.den   = i_cfg.input_max;
    assign o_out_valid     = r_out_valid;
    assign o_left_speed    = $signed(r_out_left);
    assign o_right_speed   = $signed(r_out_right);
    assign o_scale_error   = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ttm_pkg::RST_START_EN;
            r_thr       <= ttm_pkg::RST_MID;
            r_str       <= ttm_pkg::RST_MID;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Register events land in the cycle after the write, before any later command acts.
            if (i_evt.recenter) begin
                r_thr <= w_mid;
                r_str <= w_mid;
            end
            if (i_evt.set_active) begin
                r_active <= i_evt.active_val;
            end
            // In S_OUT the output register is reloaded below when it is empty or the old beat leaves.
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_value <= i_value;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_state <= S_IDLE;
                    if (r_func == ttm_pkg::FUNC_ENABLE) begin
                        r_active <= (r_value != '0);
                    end else if (r_active && r_func == ttm_pkg::FUNC_THROTTLE) begin
                        r_thr   <= w_thr_new;
                        r_state <= S_MIX;
                    end else if (r_active && r_func == ttm_pkg::FUNC_STEERING) begin
                        r_str   <= w_clamped;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_sum_l <= w_thr_s + w_str_s - w_mid_w;
                    r_sum_r <= w_thr_s - w_str_s + w_mid_w;
                    r_phase <= 1'b0;
                    if (i_cfg.input_max == '0) begin
                        r_left  <= '0;
                        r_right <= '0;
                        r_err   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_err   <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_neg   <= w_sel[ttm_pkg::SUM_W-1];
                    r_prod  <= w_mag * i_cfg.output_max;
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_div_rsp.done) begin
                        if (r_phase) begin
                            r_right <= w_sat;
                            r_state <= S_OUT;
                        end else begin
                            r_left  <= w_sat;
                            r_phase <= 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_left  <= r_left;
                        r_out_right <= r_right;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
